// ----- hdl/prg_pkg.sv -----
// shared types, sizes and helpers for the prewitt rgb gradient magnitude block
// no dependencies; used by every module of the block but prg_line_ram
package prg_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  localparam int ChW   = 8;
  localparam int NumCh = 3;

  // configuration port
  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 11;
  localparam logic [CfgIdxW-1:0] CFG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_IMAGE_HEIGHT = 1'b1;

  localparam int WidthW   = $clog2(MAX_WIDTH + 1);
  localparam int HeightW  = $clog2(MAX_HEIGHT + 1);
  localparam int ColW     = $clog2(MAX_WIDTH);
  localparam int RowIdxW  = $clog2(MAX_HEIGHT);
  // row counter runs up to height + 1 while draining
  localparam int RowW     = $clog2(MAX_HEIGHT + 2);

  localparam int RESET_WIDTH  = 640;
  localparam int RESET_HEIGHT = 480;

  // gradient arithmetic
  localparam int SumW  = ChW + 2;
  localparam int GradW = SumW + 1;
  localparam int SqW   = 2 * SumW;
  localparam int SsW   = SqW + 1;
  localparam int RadW  = 2 * ChW;

  typedef struct packed {
    logic [ChW-1:0] red_in;
    logic [ChW-1:0] green_in;
    logic [ChW-1:0] blue_in;
    logic           flush;
  } in_t;

  typedef struct packed {
    logic [ChW-1:0] red_mag;
    logic [ChW-1:0] green_mag;
    logic [ChW-1:0] blue_mag;
    logic           frame_last;
  } out_t;

  // index 2 red, 1 green, 0 blue
  typedef logic [NumCh-1:0][ChW-1:0] rgb_t;

  typedef struct packed {
    rgb_t top;
    rgb_t mid;
    rgb_t bot;
  } col_t;

  typedef struct packed {
    rgb_t above;
    rgb_t middle;
  } line_t;

  typedef struct packed {
    col_t lft;
    col_t ctr;
    col_t rgt;
    logic gx_on;
    logic gy_on;
  } win_t;

  typedef struct packed {
    logic [NumCh-1:0]           sat;
    logic [NumCh-1:0][RadW-1:0] rad;
  } sq_t;

  function automatic logic [WidthW-1:0] clamp_width(logic [CfgDataW-1:0] v);
    int unsigned iv;
    iv = v;
    if (iv == 0) iv = 1;
    else if (iv > MAX_WIDTH) iv = MAX_WIDTH;
    return WidthW'(iv);
  endfunction

  function automatic logic [HeightW-1:0] clamp_height(logic [CfgDataW-1:0] v);
    int unsigned iv;
    iv = v;
    if (iv == 0) iv = 1;
    else if (iv > MAX_HEIGHT) iv = MAX_HEIGHT;
    return HeightW'(iv);
  endfunction

endpackage

// ----- hdl/prg_line_ram.sv -----
// generic simple dual-port ram, one write and one registered read per cycle
// no dependencies; holds the two previous image rows for the top level
module prg_line_ram #(
  parameter int Width = 48,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    if (re_i) rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- hdl/prg_grad.sv -----
// three-stage gradient pipe: prewitt gx/gy, squares, sum of squares
// depends on prg_pkg; fed with a masked 3x3 window by the top level
module prg_grad (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  prg_pkg::win_t win_i,
  output logic          done_o,
  output prg_pkg::sq_t  sq_o
);
  import prg_pkg::*;

  logic [SumW-1:0]         lsum [NumCh];
  logic [SumW-1:0]         rsum [NumCh];
  logic [SumW-1:0]         tsum [NumCh];
  logic [SumW-1:0]         bsum [NumCh];
  logic signed [GradW-1:0] gx_d [NumCh];
  logic signed [GradW-1:0] gy_d [NumCh];
  logic signed [GradW-1:0] gx_q [NumCh];
  logic signed [GradW-1:0] gy_q [NumCh];
  logic [SumW-1:0]         ax   [NumCh];
  logic [SumW-1:0]         ay   [NumCh];
  logic [SqW-1:0]          sqx_q [NumCh];
  logic [SqW-1:0]          sqy_q [NumCh];
  logic [SsW-1:0]          ss   [NumCh];
  sq_t                     sq_d;
  sq_t                     sq_q;
  logic [2:0]              vld_q;

  always_comb begin
    for (int ch = 0; ch < NumCh; ch++) begin
      lsum[ch] = SumW'(win_i.lft.top[ch]) + SumW'(win_i.lft.mid[ch]) + SumW'(win_i.lft.bot[ch]);
      rsum[ch] = SumW'(win_i.rgt.top[ch]) + SumW'(win_i.rgt.mid[ch]) + SumW'(win_i.rgt.bot[ch]);
      tsum[ch] = SumW'(win_i.lft.top[ch]) + SumW'(win_i.ctr.top[ch]) + SumW'(win_i.rgt.top[ch]);
      bsum[ch] = SumW'(win_i.lft.bot[ch]) + SumW'(win_i.ctr.bot[ch]) + SumW'(win_i.rgt.bot[ch]);
      gx_d[ch] = win_i.gx_on ? ($signed({1'b0, lsum[ch]}) - $signed({1'b0, rsum[ch]})) : '0;
      gy_d[ch] = win_i.gy_on ? ($signed({1'b0, tsum[ch]}) - $signed({1'b0, bsum[ch]})) : '0;
      // magnitudes fit in SumW bits, at most three full-scale pixels
      ax[ch] = gx_q[ch][GradW-1] ? SumW'(-gx_q[ch]) : SumW'(gx_q[ch]);
      ay[ch] = gy_q[ch][GradW-1] ? SumW'(-gy_q[ch]) : SumW'(gy_q[ch]);
      ss[ch] = SsW'(sqx_q[ch]) + SsW'(sqy_q[ch]);
      sq_d.sat[ch] = |ss[ch][SsW-1:RadW];
      sq_d.rad[ch] = ss[ch][RadW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int ch = 0; ch < NumCh; ch++) begin
      if (start_i) begin
        gx_q[ch] <= gx_d[ch];
        gy_q[ch] <= gy_d[ch];
      end
      if (vld_q[0]) begin
        sqx_q[ch] <= ax[ch] * ax[ch];
        sqy_q[ch] <= ay[ch] * ay[ch];
      end
    end
    if (vld_q[1]) sq_q <= sq_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[1:0], start_i};
    end
  end

  assign done_o = vld_q[2];
  assign sq_o   = sq_q;

endmodule

// ----- hdl/prg_isqrt.sv -----
// bit-serial integer square root, three lanes in step, two radicand bits a cycle
// depends on prg_pkg; saturates to full scale when the sum overflowed 16 bits
module prg_isqrt (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  prg_pkg::sq_t  sq_i,
  output logic          done_o,
  output prg_pkg::rgb_t mag_o
);
  import prg_pkg::*;

  localparam int StepCnt = RadW / 2;
  localparam int StepW   = $clog2(StepCnt);
  localparam int RemW    = ChW + 2;
  localparam int ShW     = RemW + 2;

  logic [RadW-1:0]  rad_q  [NumCh];
  logic [RemW-1:0]  rem_q  [NumCh];
  logic [ChW-1:0]   root_q [NumCh];
  logic [NumCh-1:0] sat_q;
  logic [ShW-1:0]   rem_sh [NumCh];
  logic [ShW-1:0]   trial  [NumCh];
  logic             ge     [NumCh];
  logic [RemW-1:0]  rem_n  [NumCh];
  logic [ChW-1:0]   root_n [NumCh];
  logic [StepW-1:0] cnt_q;
  logic             busy_q;
  logic             done_q;

  always_comb begin
    for (int ch = 0; ch < NumCh; ch++) begin
      rem_sh[ch] = {rem_q[ch], rad_q[ch][RadW-1 -: 2]};
      trial[ch]  = ShW'({root_q[ch], 2'b01});
      ge[ch]     = rem_sh[ch] >= trial[ch];
      // remainder stays below 2*root+1, so it fits RemW bits either way
      rem_n[ch]  = ge[ch] ? RemW'(rem_sh[ch] - trial[ch]) : RemW'(rem_sh[ch]);
      root_n[ch] = {root_q[ch][ChW-2:0], ge[ch]};
      mag_o[ch]  = sat_q[ch] ? {ChW{1'b1}} : root_q[ch];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int ch = 0; ch < NumCh; ch++) begin
      if (start_i) begin
        rad_q[ch]  <= sq_i.rad[ch];
        rem_q[ch]  <= '0;
        root_q[ch] <= '0;
        sat_q[ch]  <= sq_i.sat[ch];
      end else if (busy_q) begin
        rad_q[ch]  <= {rad_q[ch][RadW-3:0], 2'b00};
        rem_q[ch]  <= rem_n[ch];
        root_q[ch] <= root_n[ch];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= StepW'(StepCnt - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;

endmodule

// ----- hdl/prewitt_rgb_gradient_magnitude.sv -----
// top level: sequencer, line-store read-modify-write, window and frame counters
// depends on prg_pkg, prg_line_ram, prg_grad and prg_isqrt
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-------------------------
//  in      | to block  | in_valid_i / in_stall_o  | in_data_i  (prg_pkg::in_t)
//  out     | from block| out_valid_o / out_stall_i| out_data_o (prg_pkg::out_t)
//  cfg     | to block  | cfg_we_i                 | cfg_idx_i, cfg_data_i
//
// a request that makes no result does a line-store read, then a write-back
// a request that makes a result also runs the gradient pipe, square root and output register
// a drain request on a single-row frame may step twice, rereading the line store between
// the next request is taken while a result still waits in the output register
// reset clears control and window columns; the line store is left as junk until written
module prewitt_rgb_gradient_magnitude (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  prg_pkg::in_t                   in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output prg_pkg::out_t                  out_data_o,
  input  logic                           cfg_we_i,
  input  logic [prg_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [prg_pkg::CfgDataW-1:0]   cfg_data_i
);
  import prg_pkg::*;

  localparam logic [2:0] StIdle   = 3'd0;
  localparam logic [2:0] StAdv    = 3'd1;
  localparam logic [2:0] StReread = 3'd2;
  localparam logic [2:0] StGrad   = 3'd3;
  localparam logic [2:0] StRoot   = 3'd4;
  localparam logic [2:0] StOut    = 3'd5;

  logic [2:0]         state_q, state_d;
  logic [ColW-1:0]    ci_q, ci_d;
  logic [RowW-1:0]    ri_q, ri_d;
  logic [WidthW-1:0]  width_q, width_d;
  logic [HeightW-1:0] height_q, height_d;
  rgb_t               px_q, px_d;
  logic               drain_q, drain_d;
  logic               pass_q, pass_d;
  col_t               wa_q, wa_d;
  col_t               wb_q, wb_d;
  logic               last_q, last_d;
  out_t               out_q, out_d;
  logic               out_valid_q, out_valid_d;

  logic               ram_re, ram_we;
  logic [ColW-1:0]    ram_raddr;
  line_t              ram_wdata, ram_rdata;

  logic               grad_start, grad_done, root_start, root_done;
  win_t               win;
  sq_t                sq;
  rgb_t               mag;

  logic               accept, draining;
  col_t               nc;
  logic               emit_a, emit_b, emit;
  logic [RowIdxW-1:0] e_row;
  logic [ColW-1:0]    e_col;
  logic               col_first, col_end, row_first, row_end;
  logic [ColW:0]      ci_inc;
  logic               wrap;

  function automatic col_t mask_rows(col_t c, logic top_off, logic bot_off);
    col_t m;
    m = c;
    if (top_off) m.top = '0;
    if (bot_off) m.bot = '0;
    return m;
  endfunction

  prg_line_ram #(
    .Width ($bits(line_t)),
    .Depth (MAX_WIDTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ci_q),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  prg_grad u_grad (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (grad_start),
    .win_i   (win),
    .done_o  (grad_done),
    .sq_o    (sq)
  );

  prg_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (root_start),
    .sq_i    (sq),
    .done_o  (root_done),
    .mag_o   (mag)
  );

  assign in_stall_o  = (state_q != StIdle);
  assign accept      = in_valid_i && !in_stall_o;
  assign draining    = int'(ri_q) >= int'(height_q);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // window step: new column from the two stored rows and the incoming pixel
  always_comb begin
    nc.top = ram_rdata.above;
    nc.mid = ram_rdata.middle;
    nc.bot = px_q;

    // start of a row finishes the last pixel of the row before last
    emit_a = (ci_q == '0) && (ri_q >= RowW'(2));
    emit_b = (ci_q != '0) && (ri_q != '0);
    emit   = emit_a || emit_b;
    e_row  = emit_a ? RowIdxW'(ri_q - RowW'(2)) : RowIdxW'(ri_q - RowW'(1));
    e_col  = emit_a ? ColW'(width_q - WidthW'(1)) : ci_q - ColW'(1);

    col_first = (e_col == '0);
    col_end   = (int'(e_col) + 1 == int'(width_q));
    row_first = (e_row == '0);
    row_end   = (int'(e_row) + 1 == int'(height_q));

    win.lft   = mask_rows(col_first ? '0 : wa_q, row_first, row_end);
    win.ctr   = mask_rows(wb_q, row_first, row_end);
    win.rgt   = mask_rows(col_end ? '0 : nc, row_first, row_end);
    win.gx_on = !col_first && !col_end;
    win.gy_on = !row_first && !row_end;

    ci_inc = {1'b0, ci_q} + 1'b1;
    wrap   = int'(ci_inc) >= int'(width_q);
  end

  always_comb begin
    state_d     = state_q;
    ci_d        = ci_q;
    ri_d        = ri_q;
    width_d     = width_q;
    height_d    = height_q;
    px_d        = px_q;
    drain_d     = drain_q;
    pass_d      = pass_q;
    wa_d        = wa_q;
    wb_d        = wb_q;
    last_d      = last_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    ram_re      = 1'b0;
    ram_raddr   = ci_q;
    ram_we      = 1'b0;
    ram_wdata   = '{above: ram_rdata.middle, middle: px_q};
    grad_start  = 1'b0;
    root_start  = 1'b0;

    case (state_q)
      StIdle: begin
        // a flush inside the frame is dropped; a pixel while draining counts as flush
        if (accept && (draining || !in_data_i.flush)) begin
          px_d    = draining ? '0 : {in_data_i.red_in, in_data_i.green_in, in_data_i.blue_in};
          drain_d = draining;
          pass_d  = 1'b0;
          ram_re  = 1'b1;
          state_d = StAdv;
        end
      end
      StAdv: begin
        ram_we = 1'b1;
        wa_d   = wb_q;
        wb_d   = nc;
        if (wrap) begin
          ci_d = '0;
          ri_d = ri_q + 1'b1;
        end else begin
          ci_d = ci_inc[ColW-1:0];
        end
        if (emit) begin
          grad_start = 1'b1;
          last_d     = row_end && col_end;
          if (row_end && col_end) begin
            ci_d = '0;
            ri_d = '0;
          end
          state_d = StGrad;
        end else if (drain_q && !pass_q) begin
          // single-row frame: step past the position that gives nothing
          pass_d  = 1'b1;
          state_d = StReread;
        end else begin
          state_d = StIdle;
        end
      end
      StReread: begin
        // read issued after the write-back, so an entry just written reads back updated
        ram_re  = 1'b1;
        state_d = StAdv;
      end
      StGrad: begin
        if (grad_done) begin
          root_start = 1'b1;
          state_d    = StRoot;
        end
      end
      StRoot: begin
        if (root_done) state_d = StOut;
      end
      StOut: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d       = '{red_mag: mag[2], green_mag: mag[1], blue_mag: mag[0],
                          frame_last: last_q};
          out_valid_d = 1'b1;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase

    // a register write restarts the frame
    if (cfg_we_i) begin
      ci_d = '0;
      ri_d = '0;
      case (cfg_idx_i)
        CFG_IMAGE_WIDTH:  width_d  = clamp_width(cfg_data_i);
        CFG_IMAGE_HEIGHT: height_d = clamp_height(cfg_data_i);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      ci_q        <= '0;
      ri_q        <= '0;
      width_q     <= WidthW'(RESET_WIDTH);
      height_q    <= HeightW'(RESET_HEIGHT);
      drain_q     <= 1'b0;
      pass_q      <= 1'b0;
      wa_q        <= '0;
      wb_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ci_q        <= ci_d;
      ri_q        <= ri_d;
      width_q     <= width_d;
      height_q    <= height_d;
      drain_q     <= drain_d;
      pass_q      <= pass_d;
      wa_q        <= wa_d;
      wb_q        <= wb_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    px_q   <= px_d;
    last_q <= last_d;
    out_q  <= out_d;
  end

endmodule

// ----- hdl/prg_checker.sv -----
// port-level checks on the prewitt gradient block, bound to the top level
// depends on prg_pkg and prewitt_rgb_gradient_magnitude
module prg_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input prg_pkg::in_t                  in_data_i,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input prg_pkg::out_t                 out_data_o,
  input logic                          cfg_we_i,
  input logic [prg_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input logic [prg_pkg::CfgDataW-1:0]  cfg_data_i
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed or vanished");

  // a pixel request always starts work, so the input stalls next cycle
  a_pixel_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && !in_data_i.flush |=> in_stall_o)
    else $error("pixel request taken without starting work");

  // a new result only appears at the end of a request in progress
  a_out_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared while the block was idle");

  // while idle, a result that is taken is not shown again
  a_no_repeat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !in_stall_o |=> !out_valid_o)
    else $error("result repeated after it was taken");

endmodule

bind prewitt_rgb_gradient_magnitude prg_checker u_prg_checker (.*);
